// ===== rtl/core/glob_list_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// glob list filter assertion macros
// shared property forms for the glob list filter core, clocked on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GLOB_LIST_FILTER_CORE_ASSERT_SVH
`define GLOB_LIST_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define GLF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GLF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/glf_pkg.sv =====
// ----------------------------------------------------------------------------
// glob list filter package
// transaction types, register indexes, filter modes and glob characters
// ----------------------------------------------------------------------------
`default_nettype none

package glf_pkg;

    localparam int NUM_PATTERNS_DEFAULT = 16;
    localparam int PATTERN_LEN_DEFAULT  = 32;

    localparam int SLOT_W     = 4;
    localparam int POS_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // item kinds
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_NAME    = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 1'b1;

    // filter modes
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MATCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SKIP  = 2'd2;

    // glob characters
    localparam logic [BYTE_W-1:0] GLOB_ANY_RUN = 8'h2a;
    localparam logic [BYTE_W-1:0] GLOB_ANY_ONE = 8'h3f;
    localparam logic [BYTE_W-1:0] GLOB_END     = 8'h00;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] pattern_slot;
        logic [POS_W-1:0]  char_position;
        logic [BYTE_W-1:0] byte_value;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic matched;
        logic keep;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/glf_ram.sv =====
// ----------------------------------------------------------------------------
// glob list filter ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module glf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/glob_list_filter_core.sv =====
// a name byte is not accepted until the previous item is done, that is after the sweep
// that reads and rewrites one pattern's position set per cycle
// a result is raised from ST_DONE after the sweep for the last byte of a name
// a pattern byte is a read-modify-write of one pattern row
// reset clears control and configuration registers; pattern rows are undefined until written
// ----------------------------------------------------------------------------
// glob list filter core
// matches streamed names against a stored list of glob patterns with a
// position set per pattern kept in memory and updated one pattern a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module glob_list_filter_core #(
    parameter int NUM_PATTERNS = glf_pkg::NUM_PATTERNS_DEFAULT,
    parameter int PATTERN_LEN  = glf_pkg::PATTERN_LEN_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire glf_pkg::item_t                item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output glf_pkg::result_t                   result,
    input  wire logic                          cfg_write_en,
    input  wire logic [glf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [glf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int CMP_W = (IDX_W > glf_pkg::COUNT_W) ? IDX_W : glf_pkg::COUNT_W;
    localparam int ROW_W = PATTERN_LEN * glf_pkg::BYTE_W;
    localparam int SET_W = PATTERN_LEN + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PWRITE = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                sweep_idx_reg, sweep_idx_next;
    logic [IDX_W-1:0]                wr_slot_reg, wr_slot_next;
    logic [glf_pkg::POS_W-1:0]       wr_pos_reg, wr_pos_next;
    logic [glf_pkg::BYTE_W-1:0]      item_byte_reg, item_byte_next;
    logic                            item_last_reg, item_last_next;
    logic                            name_start_reg, name_start_next;
    logic                            matched_reg, matched_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic                            s1_valid_reg;
    logic [IDX_W-1:0]                s1_idx_reg;
    logic [SET_W-1:0]                s1_set_reg;
    logic [PATTERN_LEN-1:0]          s1_star_reg;
    logic [PATTERN_LEN-1:0]          s1_adv_reg;
    logic [SET_W-1:0]                s1_len_reg;
    logic [IDX_W-1:0]                rd_idx_reg;
    logic                            result_valid_reg, result_valid_next;
    glf_pkg::result_t                result_reg, result_next;
    logic [glf_pkg::COUNT_W-1:0]     pattern_count_reg;
    logic [glf_pkg::MODE_W-1:0]      filter_mode_reg;

    logic                            item_fire;
    logic                            slot_ok;
    logic                            sweep_last;
    logic                            pat_rd_en;
    logic [IDX_W-1:0]                pat_rd_addr;
    logic [ROW_W-1:0]                pat_rd_data;
    logic                            pat_we;
    logic [ROW_W-1:0]                pat_wr_data;
    logic                            set_rd_en;
    logic [SET_W-1:0]                set_rd_data;
    logic [SET_W-1:0]                set_wr_data;

    logic [PATTERN_LEN-1:0]          star_v;
    logic [PATTERN_LEN-1:0]          one_v;
    logic [PATTERN_LEN-1:0]          eq_v;
    logic [PATTERN_LEN-1:0]          zero_v;
    logic [SET_W-1:0]                zext;
    logic [SET_W-1:0]                len_oh;
    logic [SET_W-1:0]                below_len;
    logic [SET_W-1:0]                start_set;
    logic [SET_W-1:0]                cur_set;
    logic [SET_W-1:0]                adv_set;
    logic                            hit;
    logic                            in_use;
    logic                            keep_bit;

    // star runs close like a carry chain
    function automatic logic [SET_W-1:0] close_runs(input logic [SET_W-1:0] s,
                                                    input logic [PATTERN_LEN-1:0] st);
        logic [PATTERN_LEN-1:0] x;
        logic [SET_W-1:0]       sum;
        logic [SET_W-1:0]       carries;
        x       = s[PATTERN_LEN-1:0] & st;
        sum     = {1'b0, st} + {1'b0, x};
        carries = sum ^ {1'b0, st} ^ {1'b0, x};
        return s | carries;
    endfunction

    glf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_PATTERNS)
    ) u_pattern_ram (
        .clk     (clk),
        .wr_en   (pat_we),
        .wr_addr (wr_slot_reg),
        .wr_data (pat_wr_data),
        .rd_en   (pat_rd_en),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    glf_ram #(
        .WIDTH (SET_W),
        .DEPTH (NUM_PATTERNS)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data (set_wr_data),
        .rd_en   (set_rd_en),
        .rd_addr (sweep_idx_reg),
        .rd_data (set_rd_data)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign slot_ok    = (int'(item.pattern_slot) < NUM_PATTERNS)
                     && (int'(item.char_position) < PATTERN_LEN);
    assign sweep_last = (sweep_idx_reg == IDX_W'(NUM_PATTERNS - 1));

    assign pat_rd_en   = (item_fire && item.kind == glf_pkg::KIND_PATTERN && slot_ok)
                      || (state_reg == ST_SWEEP);
    assign pat_rd_addr = (state_reg == ST_IDLE) ? IDX_W'(item.pattern_slot) : sweep_idx_reg;
    assign set_rd_en   = (state_reg == ST_SWEEP);
    assign pat_we      = (state_reg == ST_PWRITE);

    // byte merge for a pattern write
    always_comb
    begin
        for (int p = 0; p < PATTERN_LEN; p++)
        begin
            pat_wr_data[p*glf_pkg::BYTE_W +: glf_pkg::BYTE_W] =
                (p == int'(wr_pos_reg)) ? item_byte_reg
                                        : pat_rd_data[p*glf_pkg::BYTE_W +: glf_pkg::BYTE_W];
        end
    end

    // stage 1: classify pattern bytes
    always_comb
    begin
        for (int p = 0; p < PATTERN_LEN; p++)
        begin
            star_v[p] = (pat_rd_data[p*glf_pkg::BYTE_W +: glf_pkg::BYTE_W]
                         == glf_pkg::GLOB_ANY_RUN);
            one_v[p]  = (pat_rd_data[p*glf_pkg::BYTE_W +: glf_pkg::BYTE_W]
                         == glf_pkg::GLOB_ANY_ONE);
            eq_v[p]   = (pat_rd_data[p*glf_pkg::BYTE_W +: glf_pkg::BYTE_W] == item_byte_reg);
            zero_v[p] = (pat_rd_data[p*glf_pkg::BYTE_W +: glf_pkg::BYTE_W]
                         == glf_pkg::GLOB_END);
        end
    end

    assign zext      = {1'b1, zero_v};
    assign len_oh    = zext & (~zext + SET_W'(1));
    assign below_len = len_oh - SET_W'(1);
    assign start_set = close_runs({{PATTERN_LEN{1'b0}}, 1'b1}, star_v);
    assign cur_set   = name_start_reg ? start_set : set_rd_data;

    // stage 2: advance by one byte, then close star runs
    assign adv_set     = {1'b0, s1_set_reg[PATTERN_LEN-1:0] & s1_star_reg}
                       | {s1_set_reg[PATTERN_LEN-1:0] & s1_adv_reg, 1'b0};
    assign set_wr_data = close_runs(adv_set, s1_star_reg);
    assign hit         = |(set_wr_data & s1_len_reg);
    assign in_use      = CMP_W'(s1_idx_reg) < CMP_W'(pattern_count_reg);

    always_comb
    begin
        unique case (filter_mode_reg)
            glf_pkg::MODE_MATCH: keep_bit = matched_reg;
            glf_pkg::MODE_SKIP:  keep_bit = ~matched_reg;
            default:             keep_bit = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        sweep_idx_next    = sweep_idx_reg;
        wr_slot_next      = wr_slot_reg;
        wr_pos_next       = wr_pos_reg;
        item_byte_next    = item_byte_reg;
        item_last_next    = item_last_reg;
        name_start_next   = name_start_reg;
        matched_next      = matched_reg;
        rd_valid_next     = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        if (s1_valid_reg && in_use && hit)
        begin
            matched_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    wr_slot_next   = IDX_W'(item.pattern_slot);
                    wr_pos_next    = item.char_position;
                    item_byte_next = item.byte_value;
                    item_last_next = item.last_byte;
                    if (item.kind == glf_pkg::KIND_NAME)
                    begin
                        sweep_idx_next = '0;
                        matched_next   = 1'b0;
                        state_next     = ST_SWEEP;
                    end
                    else if (slot_ok)
                    begin
                        state_next = ST_PWRITE;
                    end
                end
            end
            ST_PWRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                rd_valid_next  = 1'b1;
                sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !s1_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!item_last_reg)
                begin
                    name_start_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else if (!result_valid_reg || result_ready)
                begin
                    result_valid_next   = 1'b1;
                    result_next.matched = matched_reg;
                    result_next.keep    = keep_bit;
                    name_start_next     = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            sweep_idx_reg     <= '0;
            name_start_reg    <= 1'b1;
            matched_reg       <= 1'b0;
            rd_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            pattern_count_reg <= '0;
            filter_mode_reg   <= glf_pkg::MODE_NONE;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_idx_reg    <= sweep_idx_next;
            name_start_reg   <= name_start_next;
            matched_reg      <= matched_next;
            rd_valid_reg     <= rd_valid_next;
            s1_valid_reg     <= rd_valid_reg;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    glf_pkg::REG_PATTERN_COUNT:
                    begin
                        pattern_count_reg <= cfg_data[glf_pkg::COUNT_W-1:0];
                    end
                    glf_pkg::REG_FILTER_MODE:
                    begin
                        filter_mode_reg <= cfg_data[glf_pkg::MODE_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_slot_reg   <= wr_slot_next;
        wr_pos_reg    <= wr_pos_next;
        item_byte_reg <= item_byte_next;
        item_last_reg <= item_last_next;
        result_reg    <= result_next;
        rd_idx_reg    <= sweep_idx_reg;
        s1_idx_reg    <= rd_idx_reg;
        s1_set_reg    <= cur_set;
        s1_star_reg   <= star_v & below_len[PATTERN_LEN-1:0];
        s1_adv_reg    <= (one_v | eq_v) & ~star_v & below_len[PATTERN_LEN-1:0];
        s1_len_reg    <= len_oh;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "glob_list_filter_core_assert.svh"

    `GLF_ASSERT_IMP(a_ready_when_drained, item_ready, (!rd_valid_reg && !s1_valid_reg), "ready with sweep in flight")
    `GLF_ASSERT_IMP(a_set_write_in_sweep, s1_valid_reg, (state_reg == ST_SWEEP || state_reg == ST_DRAIN), "set write outside sweep")
    `GLF_ASSERT_NXT(a_sweep_ends, (state_reg == ST_SWEEP && sweep_last), (state_reg == ST_DRAIN), "sweep overran last pattern")
    `GLF_ASSERT_NXT(a_pwrite_one_cycle, (state_reg == ST_PWRITE), (state_reg == ST_IDLE), "pattern write not single cycle")
    `GLF_ASSERT_NXT(a_result_held, (state_reg == ST_DONE && item_last_reg && result_valid_reg && !result_ready), (result_valid_reg && $stable(result_reg)), "pending result overwritten")

endmodule

`default_nettype wire
